// ===== rtl/npc_pkg.sv =====
`timescale 1ns / 1ps
package npc_pkg;

	// sizes of the item fields
	localparam int COLOR_W        = 8;
	localparam int INDEX_W        = 8;
	localparam int ENTRY_W        = 3 * COLOR_W;
	localparam int SQ_W           = 2 * COLOR_W;
	localparam int DIST_W         = SQ_W + 2;
	localparam int PALETTE_SIZE_W = 9;

	// largest number of entries an 8-bit index can name
	localparam int INDEX_LIMIT = 1 << INDEX_W;

	localparam int DEFAULT_PALETTE_DEPTH = 256;

	// register file
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [PALETTE_SIZE_W-1:0] PALETTE_SIZE_RESET = 9'd256;
	localparam logic REG_PALETTE_SIZE = 1'b0;

	// request kinds carried in tuser
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PIXEL = 1'b1
	} opcode_t;

endpackage

// ===== rtl/npc_ram.sv =====
`timescale 1ns / 1ps
module npc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/nearest_palette_color.sv =====
`timescale 1ns / 1ps
// nearest palette color lookup. a request on the slave stream either stores one
// palette entry (tuser = 0, entry index and rgb in tdata) or classifies a pixel
// (tuser = 1, rgb in tdata, tlast marks the last pixel of an image). a pixel
// gives one result on the master stream: the index of the first entry with the
// least squared rgb distance, with tlast copied from the pixel. a store request
// gives no result; a store to an index at or above PALETTE_DEPTH is dropped.
// a pixel scans the first n entries of the palette memory one entry per cycle,
// where n = min(palette_size, PALETTE_DEPTH, 256); an empty palette gives
// index 0. the result sits in an output register, so the next request is taken
// while a result still waits on the master side. palette entries hold no reset
// value and must be written before a pixel scans them. the user must change
// palette_size (register 0, byte address 0, reset 256) only while the block is
// idle; the block itself does not enforce this.
module nearest_palette_color #(
	parameter int PALETTE_DEPTH = npc_pkg::DEFAULT_PALETTE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// slave stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,  // entry_index, red, green, blue
	input  logic                              s_tuser,  // opcode
	input  logic                              s_tlast,  // end_of_image

	// master stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,  // color_index
	output logic                              m_tlast,  // last_pixel

	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [npc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [npc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [npc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	import npc_pkg::*;

	localparam int ADDR_W = $clog2(PALETTE_DEPTH);
	localparam int SEARCH_LIMIT = (PALETTE_DEPTH < INDEX_LIMIT) ? PALETTE_DEPTH : INDEX_LIMIT;

	// one-hot scan sequencer
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	// request fields
	logic [INDEX_W-1:0] in_index;
	logic [COLOR_W-1:0] in_red, in_green, in_blue;
	assign in_index = s_tdata[7:0];
	assign in_red   = s_tdata[15:8];
	assign in_green = s_tdata[23:16];
	assign in_blue  = s_tdata[31:24];

	logic in_fire;
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// configuration register
	logic [PALETTE_SIZE_W-1:0] palette_size_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PALETTE_SIZE);
	assign prdata = (paddr[2] == REG_PALETTE_SIZE) ? APB_DATA_W'(palette_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= PALETTE_SIZE_RESET;
		end else if (cfg_wr) begin
			palette_size_q <= pwdata[PALETTE_SIZE_W-1:0];
		end
	end

	// search length clamped to what the store and the index can hold
	logic [PALETTE_SIZE_W-1:0] search_len;
	assign search_len = (palette_size_q > PALETTE_SIZE_W'(SEARCH_LIMIT))
		? PALETTE_SIZE_W'(SEARCH_LIMIT) : palette_size_q;

	// palette memory ports
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W+INDEX_W-1:0] wr_addr_ext;
	logic                      rd_en;
	logic [ADDR_W-1:0]         rd_addr;
	logic [ADDR_W+PALETTE_SIZE_W-1:0] rd_addr_ext;
	logic [ENTRY_W-1:0]        rd_data;

	// scan state
	logic [PALETTE_SIZE_W-1:0] cnt_q;
	logic [PALETTE_SIZE_W-1:0] len_q;
	logic [COLOR_W-1:0]        pix_red_q, pix_green_q, pix_blue_q;
	logic                      eoi_q;

	// a store beyond the memory is dropped
	assign wr_addr_ext = {{ADDR_W{1'b0}}, in_index};
	assign wr_addr     = wr_addr_ext[ADDR_W-1:0];
	assign wr_en       = in_fire && (s_tuser == OP_WRITE) && (32'(in_index) < PALETTE_DEPTH);

	assign rd_addr_ext = {{ADDR_W{1'b0}}, cnt_q};
	assign rd_addr     = rd_addr_ext[ADDR_W-1:0];
	assign rd_en       = (state_q == ST_SCAN) && (cnt_q < len_q);

	npc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({in_red, in_green, in_blue}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage 1: entry comes out of the memory
	logic               valid_s1;
	logic [INDEX_W-1:0] idx_s1;

	// per-channel absolute differences against the pixel
	logic [COLOR_W-1:0] ent_red, ent_green, ent_blue;
	logic [COLOR_W-1:0] diff_red, diff_green, diff_blue;
	assign ent_red   = rd_data[23:16];
	assign ent_green = rd_data[15:8];
	assign ent_blue  = rd_data[7:0];
	assign diff_red   = (pix_red_q >= ent_red) ? pix_red_q - ent_red : ent_red - pix_red_q;
	assign diff_green = (pix_green_q >= ent_green) ? pix_green_q - ent_green
		: ent_green - pix_green_q;
	assign diff_blue  = (pix_blue_q >= ent_blue) ? pix_blue_q - ent_blue : ent_blue - pix_blue_q;

	// stage 2: squared channel distances
	logic               valid_s2;
	logic [INDEX_W-1:0] idx_s2;
	logic [SQ_W-1:0]    sq_red_s2, sq_green_s2, sq_blue_s2;

	// running minimum
	logic [DIST_W-1:0]  cand_dist;
	logic [DIST_W-1:0]  best_dist_q;
	logic [INDEX_W-1:0] best_q;
	logic               have_q;
	assign cand_dist = DIST_W'(sq_red_s2) + DIST_W'(sq_green_s2) + DIST_W'(sq_blue_s2);

	// result goes into the output register once the previous one has left
	logic out_load;
	assign out_load = (state_q == ST_FINISH) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1      <= cnt_q[INDEX_W-1:0];
		idx_s2      <= idx_s1;
		sq_red_s2   <= SQ_W'(diff_red) * SQ_W'(diff_red);
		sq_green_s2 <= SQ_W'(diff_green) * SQ_W'(diff_green);
		sq_blue_s2  <= SQ_W'(diff_blue) * SQ_W'(diff_blue);
	end

	// scan sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			len_q    <= '0;
			have_q   <= 1'b0;
			best_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (s_tuser == OP_PIXEL)) begin
						cnt_q   <= '0;
						len_q   <= search_len;
						have_q  <= 1'b0;
						best_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// first index wins on ties
					if (valid_s2 && (!have_q || (cand_dist < best_dist_q))) begin
						have_q <= 1'b1;
						best_q <= idx_s2;
					end
					if (!rd_en && !valid_s1 && !valid_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire && (s_tuser == OP_PIXEL)) begin
			pix_red_q   <= in_red;
			pix_green_q <= in_green;
			pix_blue_q  <= in_blue;
			eoi_q       <= s_tlast;
		end
		if ((state_q == ST_SCAN) && valid_s2 && (!have_q || (cand_dist < best_dist_q))) begin
			best_dist_q <= cand_dist;
		end
		if (out_load) begin
			m_tdata <= best_q;
			m_tlast <= eoi_q;
		end
	end

endmodule
